// ===== hw/rtl/abpc_pkg.sv =====
// ----------------------------------------------------------------------------
// abpc_pkg
// shared types, widths and codes for the analog button press classifier
// ----------------------------------------------------------------------------
package abpc_pkg;

  localparam int NOW_W      = 32;
  localparam int SAMPLE_W   = 10;
  localparam int LEVEL_W    = 10;
  localparam int MS_W       = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // queue between front and back, depth must be a power of two
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // register reset values
  localparam logic [LEVEL_W-1:0] TARGET_LEVEL_RST    = '0;
  localparam logic [LEVEL_W-1:0] LEVEL_TOLERANCE_RST = '0;
  localparam logic [MS_W-1:0]    BOUNCE_MS_RST       = 16'd50;
  localparam logic [MS_W-1:0]    LONG_PRESS_MS_RST   = 16'd2000;
  localparam logic [MS_W-1:0]    AUTO_START_MS_RST   = 16'd0;
  localparam logic [MS_W-1:0]    AUTO_PERIOD_MS_RST  = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_LEVEL    = 3'd0,
    CFG_LEVEL_TOLERANCE = 3'd1,
    CFG_BOUNCE_MS       = 3'd2,
    CFG_LONG_PRESS_MS   = 3'd3,
    CFG_AUTO_START_MS   = 3'd4,
    CFG_AUTO_PERIOD_MS  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2,
    EV_AUTO  = 2'd3
  } ev_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] target_level;
    logic [LEVEL_W-1:0] level_tolerance;
    logic [MS_W-1:0]    bounce_ms;
    logic [MS_W-1:0]    long_press_ms;
    logic [MS_W-1:0]    auto_start_ms;
    logic [MS_W-1:0]    auto_period_ms;
  } cfg_t;

  // one classified poll: timestamp plus level decision
  typedef struct packed {
    logic [NOW_W-1:0] now_ms;
    logic             act;
  } item_t;

endpackage

// ===== hw/rtl/analog_button_press_classifier.sv =====
// ----------------------------------------------------------------------------
// analog_button_press_classifier
// debounced click, long click and auto-repeat detection on a ladder adc pin
// ----------------------------------------------------------------------------
// usage
//   in_*  : one poll per transaction, millisecond timestamp plus adc sample
//   out_* : one event code per poll, in poll order (none, click, long, auto)
//   cfg_* : register writes, taken in the cycle cfg_we is high; unknown
//           indexes are dropped; the user writes only while no poll is
//           in flight, a rule the block itself leaves unenforced
// input to out_valid passes front register, queue slot and result register
// throughput: one poll per cycle while out_ready stays high; the press state
//   update in the back end loops on its own registers, so it sets the rate
// reset (synchronous, rst_n low): registers to their defaults, press state
//   and timestamps to zero, queue and output empty
// a stalled receiver holds the result register; the back end stops
//   popping, the two-entry queue and the front register fill, and only then
//   in_ready drops
// ----------------------------------------------------------------------------
module analog_button_press_classifier (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [abpc_pkg::NOW_W-1:0]      in_now_ms,
  input  logic [abpc_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_event_res,
  input  logic                            cfg_we,
  input  logic [abpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [abpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  abpc_pkg::cfg_t cfg_r, cfg_nxt;

  // front to queue
  logic            f_valid, f_ready;
  abpc_pkg::item_t f_item;
  // queue to back
  logic            b_valid, b_ready;
  abpc_pkg::item_t b_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        abpc_pkg::CFG_TARGET_LEVEL: begin
          cfg_nxt.target_level = cfg_wdata[abpc_pkg::LEVEL_W-1:0];
        end
        abpc_pkg::CFG_LEVEL_TOLERANCE: begin
          cfg_nxt.level_tolerance = cfg_wdata[abpc_pkg::LEVEL_W-1:0];
        end
        abpc_pkg::CFG_BOUNCE_MS: begin
          cfg_nxt.bounce_ms = cfg_wdata[abpc_pkg::MS_W-1:0];
        end
        abpc_pkg::CFG_LONG_PRESS_MS: begin
          cfg_nxt.long_press_ms = cfg_wdata[abpc_pkg::MS_W-1:0];
        end
        abpc_pkg::CFG_AUTO_START_MS: begin
          cfg_nxt.auto_start_ms = cfg_wdata[abpc_pkg::MS_W-1:0];
        end
        abpc_pkg::CFG_AUTO_PERIOD_MS: begin
          cfg_nxt.auto_period_ms = cfg_wdata[abpc_pkg::MS_W-1:0];
        end
        default: begin
          // out-of-range index: write is dropped
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_level    <= abpc_pkg::TARGET_LEVEL_RST;
      cfg_r.level_tolerance <= abpc_pkg::LEVEL_TOLERANCE_RST;
      cfg_r.bounce_ms       <= abpc_pkg::BOUNCE_MS_RST;
      cfg_r.long_press_ms   <= abpc_pkg::LONG_PRESS_MS_RST;
      cfg_r.auto_start_ms   <= abpc_pkg::AUTO_START_MS_RST;
      cfg_r.auto_period_ms  <= abpc_pkg::AUTO_PERIOD_MS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: window compare on the sample
  abpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_now_ms (in_now_ms),
    .in_sample (in_sample),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_item    (f_item)
  );

  // decoupling queue
  abpc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  // back: press state and event decision
  abpc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (b_valid),
    .q_ready       (b_ready),
    .q_item        (b_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_res (out_event_res)
  );

endmodule

// ===== hw/rtl/abpc_front.sv =====
// ----------------------------------------------------------------------------
// abpc_front
// accepts polls and decides whether the sample lies in the button's window
// ----------------------------------------------------------------------------
module abpc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  abpc_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [abpc_pkg::NOW_W-1:0]    in_now_ms,
  input  logic [abpc_pkg::SAMPLE_W-1:0] in_sample,
  output logic                          q_valid,
  input  logic                          q_ready,
  output abpc_pkg::item_t               q_item
);

  logic                         vld_r, vld_nxt;
  abpc_pkg::item_t              item_r, item_nxt;
  logic [abpc_pkg::LEVEL_W-1:0] lo;
  logic [abpc_pkg::LEVEL_W:0]   hi;
  logic                         act;

  // window bounds, lower bound clamps at zero
  always_comb begin
    lo  = (cfg.target_level > cfg.level_tolerance) ?
          (cfg.target_level - cfg.level_tolerance) : '0;
    hi  = {1'b0, cfg.target_level} + {1'b0, cfg.level_tolerance};
    act = (in_sample >= lo) && ({1'b0, in_sample} <= hi);
  end

  assign in_ready = !vld_r || q_ready;

  always_comb begin
    vld_nxt  = vld_r;
    item_nxt = item_r;
    if (in_ready) begin
      vld_nxt         = in_valid;
      item_nxt.now_ms = in_now_ms;
      item_nxt.act    = act;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    item_r <= item_nxt;
  end

  assign q_valid = vld_r;
  assign q_item  = item_r;

endmodule

// ===== hw/rtl/abpc_queue.sv =====
// ----------------------------------------------------------------------------
// abpc_queue
// short queue of classified polls between front and back
// ----------------------------------------------------------------------------
module abpc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  abpc_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output abpc_pkg::item_t pop_item
);

  abpc_pkg::item_t              mem_r [abpc_pkg::Q_DEPTH];
  logic [abpc_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [abpc_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [abpc_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                         push, pop;

  assign push_ready = (cnt_r != abpc_pkg::Q_CNT_W'(abpc_pkg::Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  // pointers wrap on their own since depth is a power of two
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/abpc_back.sv =====
// ----------------------------------------------------------------------------
// abpc_back
// press state tracking and event decision, with registered result
// ----------------------------------------------------------------------------
module abpc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  abpc_pkg::cfg_t             cfg,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  abpc_pkg::item_t            q_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_event_res
);

  logic                       pressed_r, pressed_nxt;
  logic                       long_seen_r, long_seen_nxt;
  logic                       auto_seen_r, auto_seen_nxt;
  logic [abpc_pkg::NOW_W-1:0] release_time_r, release_time_nxt;
  logic [abpc_pkg::NOW_W-1:0] press_time_r, press_time_nxt;
  logic [abpc_pkg::NOW_W-1:0] last_auto_r, last_auto_nxt;
  logic                       out_valid_r, out_valid_nxt;
  abpc_pkg::ev_t              out_event_r, out_event_nxt;

  logic                       pop;
  logic [abpc_pkg::NOW_W-1:0] d_rel, d_press, d_auto;
  logic                       press_hit, long_hit, auto_hit, rel_hit;
  logic                       long_en, auto_en;
  abpc_pkg::ev_t              ev;

  assign q_ready = !out_valid_r || out_ready;
  assign pop     = q_valid && q_ready;

  // elapsed times wrap modulo 2^32
  always_comb begin
    d_rel   = q_item.now_ms - release_time_r;
    d_press = q_item.now_ms - press_time_r;
    d_auto  = q_item.now_ms - last_auto_r;
    long_en = (cfg.long_press_ms != '0);
    auto_en = (cfg.auto_start_ms != '0);
    // a fresh press restarts the hold time and has priority, so long and auto cannot fire with it
    press_hit = q_item.act && !pressed_r &&
                (d_rel > abpc_pkg::NOW_W'(cfg.bounce_ms));
    long_hit  = q_item.act && !long_seen_r && long_en &&
                (d_press > abpc_pkg::NOW_W'(cfg.long_press_ms));
    auto_hit  = q_item.act && auto_en &&
                (d_press > abpc_pkg::NOW_W'(cfg.auto_start_ms)) &&
                (d_auto > abpc_pkg::NOW_W'(cfg.auto_period_ms));
    rel_hit   = !q_item.act && pressed_r &&
                (d_press > abpc_pkg::NOW_W'(cfg.bounce_ms));
  end

  always_comb begin
    pressed_nxt      = pressed_r;
    long_seen_nxt    = long_seen_r;
    auto_seen_nxt    = auto_seen_r;
    release_time_nxt = release_time_r;
    press_time_nxt   = press_time_r;
    last_auto_nxt    = last_auto_r;
    ev               = abpc_pkg::EV_NONE;
    priority if (press_hit) begin
      pressed_nxt    = 1'b1;
      long_seen_nxt  = 1'b0;
      auto_seen_nxt  = 1'b0;
      press_time_nxt = q_item.now_ms;
      if (!long_en && !auto_en) begin
        ev = abpc_pkg::EV_CLICK;
      end
    end else if (long_hit) begin
      long_seen_nxt = 1'b1;
      ev            = abpc_pkg::EV_LONG;
    end else if (auto_hit) begin
      auto_seen_nxt = 1'b1;
      last_auto_nxt = q_item.now_ms;
      ev            = abpc_pkg::EV_AUTO;
    end else if (rel_hit) begin
      pressed_nxt      = 1'b0;
      release_time_nxt = q_item.now_ms;
      if ((long_en || auto_en) && !long_seen_r && !auto_seen_r) begin
        ev = abpc_pkg::EV_CLICK;
      end
    end else begin
      ev = abpc_pkg::EV_NONE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_event_nxt = out_event_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      out_event_nxt = ev;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r      <= 1'b0;
      long_seen_r    <= 1'b0;
      auto_seen_r    <= 1'b0;
      release_time_r <= '0;
      press_time_r   <= '0;
      last_auto_r    <= '0;
      out_valid_r    <= 1'b0;
    end else if (pop) begin
      pressed_r      <= pressed_nxt;
      long_seen_r    <= long_seen_nxt;
      auto_seen_r    <= auto_seen_nxt;
      release_time_r <= release_time_nxt;
      press_time_r   <= press_time_nxt;
      last_auto_r    <= last_auto_nxt;
      out_valid_r    <= out_valid_nxt;
    end else begin
      out_valid_r    <= out_valid_nxt;
    end
    out_event_r <= out_event_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;

  a_long_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && ev == abpc_pkg::EV_LONG) |=> long_seen_r)
    else $error("long event without long flag set");

  a_press_stamps: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && press_hit) |=> (pressed_r && press_time_r == $past(q_item.now_ms)))
    else $error("press did not record its timestamp");

  a_auto_stamps: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && ev == abpc_pkg::EV_AUTO) |=>
      (auto_seen_r && last_auto_r == $past(q_item.now_ms)))
    else $error("auto event did not record its timestamp");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && rel_hit && !press_hit && !long_hit && !auto_hit) |=>
      (!pressed_r && release_time_r == $past(q_item.now_ms)))
    else $error("release did not clear pressed state");

endmodule

// ===== tb/analog_button_press_classifier_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// analog_button_press_classifier_test
// drives timestamped adc polls through the classifier and checks every event
// code against an in-bench model of the press, long, auto and release rules
// ----------------------------------------------------------------------------
module analog_button_press_classifier_test;

  // indexes past the register map, writes there must be dropped
  localparam logic [abpc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [abpc_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

  localparam int  RANDOM_POLLS = 1830;
  localparam int  PHASE_POLLS  = 150;
  localparam int  HOLD_CYCLES  = 80;
  localparam int  DRAIN_CYCLES = 16;
  localparam int  MAX_PRINTS   = 40;
  localparam time RUN_LIMIT_NS = 2_000_000;

  // --------------------------------------------------------------------------
  // event scoreboard: mirrors the press state, predicts one code per poll
  // --------------------------------------------------------------------------
  class button_event_book;
    abpc_pkg::cfg_t regs;
    bit             pressed;
    bit             long_seen;
    bit             auto_seen;
    logic [31:0]    release_ms;
    logic [31:0]    press_ms;
    logic [31:0]    last_auto_ms;
    abpc_pkg::ev_t  events_due[$];
    int             errors;
    int             checked;
    int             seen[4];

    function new();
      regs.target_level    = abpc_pkg::TARGET_LEVEL_RST;
      regs.level_tolerance = abpc_pkg::LEVEL_TOLERANCE_RST;
      regs.bounce_ms       = abpc_pkg::BOUNCE_MS_RST;
      regs.long_press_ms   = abpc_pkg::LONG_PRESS_MS_RST;
      regs.auto_start_ms   = abpc_pkg::AUTO_START_MS_RST;
      regs.auto_period_ms  = abpc_pkg::AUTO_PERIOD_MS_RST;
      pressed      = 1'b0;
      long_seen    = 1'b0;
      auto_seen    = 1'b0;
      release_ms   = '0;
      press_ms     = '0;
      last_auto_ms = '0;
      errors       = 0;
      checked      = 0;
    endfunction

    function void write_reg(logic [abpc_pkg::CFG_IDX_W-1:0] idx,
                            logic [abpc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        abpc_pkg::CFG_TARGET_LEVEL:    regs.target_level    = data[abpc_pkg::LEVEL_W-1:0];
        abpc_pkg::CFG_LEVEL_TOLERANCE: regs.level_tolerance = data[abpc_pkg::LEVEL_W-1:0];
        abpc_pkg::CFG_BOUNCE_MS:       regs.bounce_ms       = data;
        abpc_pkg::CFG_LONG_PRESS_MS:   regs.long_press_ms   = data;
        abpc_pkg::CFG_AUTO_START_MS:   regs.auto_start_ms   = data;
        abpc_pkg::CFG_AUTO_PERIOD_MS:  regs.auto_period_ms  = data;
        default: ;
      endcase
    endfunction

    function bit level_hit(logic [abpc_pkg::SAMPLE_W-1:0] s);
      int lo;
      int hi;
      lo = (regs.target_level > regs.level_tolerance) ?
           int'(regs.target_level) - int'(regs.level_tolerance) : 0;
      hi = int'(regs.target_level) + int'(regs.level_tolerance);
      return (int'(s) >= lo) && (int'(s) <= hi);
    endfunction

    function abpc_pkg::ev_t classify_poll(logic [abpc_pkg::NOW_W-1:0] now,
                                          logic [abpc_pkg::SAMPLE_W-1:0] s);
      bit          act;
      logic [31:0] since_press;
      logic [31:0] since_auto;
      act = level_hit(s);
      if (act && !pressed && (now - release_ms) > 32'(regs.bounce_ms)) begin
        long_seen = 1'b0;
        auto_seen = 1'b0;
        pressed   = 1'b1;
        press_ms  = now;
        if (regs.long_press_ms == 0 && regs.auto_start_ms == 0) return abpc_pkg::EV_CLICK;
      end
      since_press = now - press_ms;
      since_auto  = now - last_auto_ms;
      if (act && !long_seen && regs.long_press_ms != 0 &&
          since_press > 32'(regs.long_press_ms)) begin
        long_seen = 1'b1;
        return abpc_pkg::EV_LONG;
      end
      if (act && regs.auto_start_ms != 0 && since_press > 32'(regs.auto_start_ms) &&
          since_auto > 32'(regs.auto_period_ms)) begin
        auto_seen    = 1'b1;
        last_auto_ms = now;
        return abpc_pkg::EV_AUTO;
      end
      if (!act && pressed && since_press > 32'(regs.bounce_ms)) begin
        pressed    = 1'b0;
        release_ms = now;
        if ((regs.long_press_ms != 0 || regs.auto_start_ms != 0) &&
            !long_seen && !auto_seen) return abpc_pkg::EV_CLICK;
      end
      return abpc_pkg::EV_NONE;
    endfunction

    function void note_poll(logic [abpc_pkg::NOW_W-1:0] now,
                            logic [abpc_pkg::SAMPLE_W-1:0] s);
      events_due.push_back(classify_poll(now, s));
    endfunction

    function int pending();
      return events_due.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("[%0t] event mismatch: %s", $time, msg);
    endtask

    task check_event(logic [1:0] got);
      abpc_pkg::ev_t want;
      if (events_due.size() == 0) begin
        report($sformatf("code %0d arrived with no poll outstanding", got));
        return;
      end
      want = events_due.pop_front();
      checked++;
      if (got !== want)
        report($sformatf("poll %0d gave code %0d, want %s", checked, got, want.name()));
      else
        seen[want]++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // signals
  // --------------------------------------------------------------------------
  logic                            clk           = 1'b0;
  logic                            rst_n         = 1'b0;
  logic                            in_valid      = 1'b0;
  logic                            in_ready;
  logic [abpc_pkg::NOW_W-1:0]      in_now_ms     = '0;
  logic [abpc_pkg::SAMPLE_W-1:0]   in_sample     = '0;
  logic                            out_valid;
  logic                            out_ready     = 1'b0;
  logic [1:0]                      out_event_res;
  logic                            cfg_we        = 1'b0;
  logic [abpc_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [abpc_pkg::CFG_DATA_W-1:0] cfg_wdata     = '0;

  button_event_book scoreboard = new();

  // stimulus knobs, owned by the main sequence
  int             in_idle_pct   = 0;
  int             out_stall_pct = 0;
  int             polls_sent    = 0;
  int             settings_used = 0;
  int             step_max      = 8;
  logic [31:0]    poll_ms       = '0;
  abpc_pkg::cfg_t live_cfg;

  // long receiver hold-off: main bumps hold_asks, receiver process counts it out
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;

  analog_button_press_classifier uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_now_ms     (in_now_ms),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_res (out_event_res),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[%0t] timeout, %0d events still outstanding", $time, scoreboard.pending());
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random back-pressure plus the occasional long hold-off
  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // both channels are sampled at the falling edge, before the rising edge
  // that completes the transaction, so nothing races the dut
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) scoreboard.note_poll(in_now_ms, in_sample);
      if (out_valid && out_ready) scoreboard.check_event(out_event_res);
    end
  end

  // --------------------------------------------------------------------------
  // driver tasks, all entered and left just after a rising edge
  // --------------------------------------------------------------------------
  task send_poll(logic [abpc_pkg::NOW_W-1:0] now, logic [abpc_pkg::SAMPLE_W-1:0] s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_now_ms <= now;
    in_sample <= s;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    polls_sent++;
  endtask

  // drop valid and wait for every poll in flight to come out
  task settle();
    in_valid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_reg(logic [abpc_pkg::CFG_IDX_W-1:0] idx,
                 logic [abpc_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    scoreboard.write_reg(idx, data);
    @(posedge clk);
  endtask

  // level registers get junk in the unused upper data bits
  task apply_cfg(abpc_pkg::cfg_t c, bit with_unmapped);
    logic [5:0] junk_a;
    logic [5:0] junk_b;
    junk_a = 6'($urandom_range(63));
    junk_b = 6'($urandom_range(63));
    write_reg(abpc_pkg::CFG_TARGET_LEVEL,    {junk_a, c.target_level});
    write_reg(abpc_pkg::CFG_LEVEL_TOLERANCE, {junk_b, c.level_tolerance});
    write_reg(abpc_pkg::CFG_BOUNCE_MS,       c.bounce_ms);
    write_reg(abpc_pkg::CFG_LONG_PRESS_MS,   c.long_press_ms);
    write_reg(abpc_pkg::CFG_AUTO_START_MS,   c.auto_start_ms);
    write_reg(abpc_pkg::CFG_AUTO_PERIOD_MS,  c.auto_period_ms);
    if (with_unmapped) begin
      write_reg(CFG_UNMAPPED_LO, 16'($urandom));
      write_reg(CFG_UNMAPPED_HI, 16'($urandom));
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    live_cfg = c;
    settings_used++;
  endtask

  task request_hold();
    in_valid <= 1'b0;
    @(negedge clk);
    hold_asks++;
    @(posedge clk);
  endtask

  // a sample inside or outside the active window of the current setting
  function logic [abpc_pkg::SAMPLE_W-1:0] pick_level(bit want_active);
    int lo;
    int hi;
    bit below;
    bit above;
    lo = (live_cfg.target_level > live_cfg.level_tolerance) ?
         int'(live_cfg.target_level) - int'(live_cfg.level_tolerance) : 0;
    hi = int'(live_cfg.target_level) + int'(live_cfg.level_tolerance);
    if (hi > 1023) hi = 1023;
    below = (lo > 0);
    above = (hi < 1023);
    if (want_active) return abpc_pkg::SAMPLE_W'($urandom_range(hi, lo));
    if (below && (!above || $urandom_range(1) == 0))
      return abpc_pkg::SAMPLE_W'($urandom_range(lo - 1, 0));
    if (above) return abpc_pkg::SAMPLE_W'($urandom_range(1023, hi + 1));
    return abpc_pkg::SAMPLE_W'($urandom_range(1023));
  endfunction

  function void advance_time();
    poll_ms = poll_ms + 32'($urandom_range(step_max, 1));
    // rare far jump exercises the upper timestamp bits and wrap-around
    if ($urandom_range(199) == 0) poll_ms = poll_ms + $urandom;
  endfunction

  // one hold with contact bounce inside, then a release stretch
  task press_and_release();
    int hold_n;
    int rel_n;
    hold_n = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(30, 1);
    rel_n  = $urandom_range(10, 1);
    repeat (hold_n) begin
      advance_time();
      send_poll(poll_ms, pick_level($urandom_range(9) != 0));
    end
    repeat (rel_n) begin
      advance_time();
      send_poll(poll_ms, pick_level($urandom_range(9) == 0));
    end
  endtask

  task noise_poll();
    if ($urandom_range(3) == 0) poll_ms = $urandom;
    else advance_time();
    send_poll(poll_ms, abpc_pkg::SAMPLE_W'($urandom_range(1023)));
  endtask

  function abpc_pkg::cfg_t pick_cfg(int phase);
    abpc_pkg::cfg_t c;
    case (phase)
      0: begin
        // everything zero: clicks on press only, no debounce
        c = '0;
        step_max = 3;
      end
      1: begin
        c.target_level    = 10'd1023;
        c.level_tolerance = 10'($urandom_range(60));
        c.bounce_ms       = 16'hFFFF;
        c.long_press_ms   = 16'hFFFF;
        c.auto_start_ms   = 16'hFFFF;
        c.auto_period_ms  = 16'hFFFF;
        step_max = 20000;
      end
      default: begin
        c.target_level    = 10'($urandom_range(1023));
        c.level_tolerance = ($urandom_range(9) < 2) ? 10'($urandom_range(1023)) :
                            10'($urandom_range(60));
        c.bounce_ms       = 16'($urandom_range(20));
        c.long_press_ms   = ($urandom_range(4) < 2) ? 16'd0 : 16'($urandom_range(150, 1));
        c.auto_start_ms   = ($urandom_range(4) < 2) ? 16'd0 : 16'($urandom_range(150, 1));
        c.auto_period_ms  = 16'($urandom_range(50));
        step_max = $urandom_range(20, 2);
      end
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int             phase;
    int             phase_end;
    abpc_pkg::cfg_t c;

    live_cfg = scoreboard.regs;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: only a sample of zero counts, 50 ms debounce
    send_poll(32'd0, 10'd0);
    send_poll(32'd51, 10'd0);
    send_poll(32'd60, 10'd1);
    settle();

    // zero tolerance at the top level, no debounce, click on press
    c = '{target_level: 10'd1023, level_tolerance: 10'd0, bounce_ms: 16'd0,
          long_press_ms: 16'd0, auto_start_ms: 16'd0, auto_period_ms: 16'd0};
    apply_cfg(c, 1'b1);
    send_poll(32'd1, 10'd1023);
    send_poll(32'd2, 10'd1022);
    send_poll(32'd3, 10'd1023);
    send_poll(32'd4, 10'd0);
    settle();

    // full window, all times at maximum, timestamps wrap; the second poll
    // sits exactly on the long threshold and must stay quiet
    c = '{target_level: 10'd0, level_tolerance: 10'd1023, bounce_ms: 16'hFFFF,
          long_press_ms: 16'hFFFF, auto_start_ms: 16'hFFFF, auto_period_ms: 16'hFFFF};
    apply_cfg(c, 1'b0);
    send_poll(32'hFFFF_0000, 10'd0);
    send_poll(32'hFFFF_FFFF, 10'd1023);
    send_poll(32'h0002_0000, 10'd512);
    send_poll(32'h0004_0000, 10'd512);
    send_poll(32'h0005_0000, 10'd1);
    settle();

    // window clipped at zero; long and auto firing while not pressed
    c = '{target_level: 10'd5, level_tolerance: 10'd10, bounce_ms: 16'd1000,
          long_press_ms: 16'd20, auto_start_ms: 16'd30, auto_period_ms: 16'd5};
    apply_cfg(c, 1'b1);
    send_poll(32'h0006_0000, 10'd16);
    send_poll(32'h0006_0010, 10'd0);
    send_poll(32'h0006_0020, 10'd15);
    send_poll(32'h0006_1000, 10'd16);
    send_poll(32'h0006_2000, 10'd0);
    send_poll(32'h0006_2010, 10'd16);
    send_poll(32'h0006_2400, 10'd16);
    send_poll(32'h0006_2410, 10'd10);
    settle();

    // random phases: mostly press gestures, some raw noise, varying pressure
    phase = 0;
    while (polls_sent < RANDOM_POLLS + 20) begin
      c = pick_cfg(phase);
      apply_cfg(c, phase % 3 == 2);
      poll_ms = $urandom;
      case (phase % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 48; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 48; end
        default: begin in_idle_pct = 32; out_stall_pct = 32; end
      endcase
      // receiver holds off while polls keep coming, so the pipe backs up
      if (phase % 4 == 2) request_hold();
      phase_end = polls_sent + PHASE_POLLS;
      while (polls_sent < phase_end) begin
        if ($urandom_range(99) < 85) press_and_release();
        else noise_poll();
      end
      settle();
      phase++;
    end

    in_idle_pct   = 0;
    out_stall_pct = 0;
    in_valid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d polls over %0d register settings, %0d mismatches",
             polls_sent, settings_used, scoreboard.errors);
    $display("events matched: %0d none, %0d click, %0d long, %0d auto",
             scoreboard.seen[abpc_pkg::EV_NONE], scoreboard.seen[abpc_pkg::EV_CLICK],
             scoreboard.seen[abpc_pkg::EV_LONG], scoreboard.seen[abpc_pkg::EV_AUTO]);
    if (scoreboard.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
